// ===== sv/srg_pkg.sv =====
// ----------------------------------------------------------------------------
// srg_pkg: shared types and constants for the shaded rectangle generator
// Command codes, register indexes, the sequencer state and the fixed point
// layout used by every module of the block.
// ----------------------------------------------------------------------------
package srg_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS      = 23;
	localparam int ACC_W          = 32;
	localparam int NCH            = 4;
	localparam int CFG_IDX_W      = 3;

	typedef enum logic [0:0] {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLOR_TL = 3'd0,
		REG_COLOR_TR = 3'd1,
		REG_COLOR_BR = 3'd2,
		REG_COLOR_BL = 3'd3,
		REG_CLIP_H   = 3'd4,
		REG_CLIP_V   = 3'd5,
		REG_ALPHA    = 3'd6
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VSTEP,    // ls/rs over unclipped height
		ST_VCLIP,    // clip top/bottom corners
		ST_HSTEP,    // ts/bs over unclipped width
		ST_HCLIP,    // clip left/right corners
		ST_FINAL,    // edge and span steps over clipped box
		ST_OUT,      // result waiting
		ST_ROW       // new row span step
	} state_t;

	// divider request / response
	typedef struct packed {
		logic              start;
		logic [ACC_W-1:0]  num;
		logic [ACC_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [ACC_W-1:0]  quo;
	} div_rsp_t;

	function automatic logic [ACC_W-1:0] chan(input logic [31:0] reg_v, input int c);
		chan = {1'b0, reg_v[8*c +: 8], {FRAC_BITS{1'b0}}};
	endfunction

endpackage

// ===== sv/shaded_rect_gradient_generator.sv =====
// ----------------------------------------------------------------------------
// shaded_rect_gradient_generator: Gouraud shaded rectangle fill
// Clips a rectangle, sets up bilinear colour steps and emits one pixel with
// its interpolated colour per step command while a fill is active.
//
//  channel  | direction | beat contents
//  s_axis   | in        | tuser command, tdata rect left/top/right/bottom
//  m_axis   | out       | tdata x/y/r/g/b/a, tlast last pixel
//  cfg      | in        | index, data
//
// A start command takes up to 28 divisions (8 + 8 + 12) plus up to 32 clip
// products, through one bit-serial divider and one multiplier. A step is
// the accept and then the result beat held until taken; a step ending a
// row adds 4 divisions. Not ready while a command is worked on or a result
// waits; reset idles it.
// ----------------------------------------------------------------------------
module shaded_rect_gradient_generator #(
	parameter int COORD_BITS = srg_pkg::COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // rect_left, rect_top, rect_right, rect_bottom
	input  logic        s_axis_tuser,  // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // pixel_x, pixel_y, red, green, blue, alpha
	output logic        m_axis_tlast,  // last_pixel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int W  = srg_pkg::ACC_W;
	localparam int CW = COORD_BITS;
	localparam int NC = srg_pkg::NCH;

	// configuration registers
	logic [31:0] col_q [4];
	logic [31:0] cliph_q, clipv_q;
	logic        alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) col_q[i] <= '0;
			cliph_q <= '0;
			clipv_q <= '0;
			alpha_q <= 1'b0;
		end else if (cfg_valid) begin
			case (srg_pkg::cfg_idx_t'(cfg_index))
				srg_pkg::REG_COLOR_TL: col_q[0] <= cfg_data;
				srg_pkg::REG_COLOR_TR: col_q[1] <= cfg_data;
				srg_pkg::REG_COLOR_BR: col_q[2] <= cfg_data;
				srg_pkg::REG_COLOR_BL: col_q[3] <= cfg_data;
				srg_pkg::REG_CLIP_H:   cliph_q  <= cfg_data;
				srg_pkg::REG_CLIP_V:   clipv_q  <= cfg_data;
				srg_pkg::REG_ALPHA:    alpha_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end
	assign cfg_ready = 1'b1;

	// corners: 0 tl, 1 tr, 2 br, 3 bl; per channel
	logic [W-1:0] cor_q [4][NC];
	logic [W-1:0] vs_q  [2][NC];  // ls, rs
	logic [W-1:0] hs_q  [2][NC];  // ts, bs
	logic [W-1:0] le_q  [NC], re_q [NC], les_q [NC], res_q [NC];
	logic [W-1:0] sa_q  [NC], ss_q [NC];
	logic signed [CW-1:0] left_q, top_q, right_q, bot_q;
	logic signed [CW-1:0] cl_q, cr_q, ct_q, cb_q;
	logic signed [CW-1:0] cx_q, cy_q, sx_q, ex_q, ey_q;
	logic         active_q;
	logic         last_q;
	logic [63:0]  obuf_q;

	srg_pkg::state_t st_q, st_d;
	logic [3:0]  idx_q;      // job index within a phase
	logic [1:0]  sub_q;      // 0 issue, 1 wait and write
	logic [16:0] hgt_q, wid_q;

	// shared units
	srg_pkg::div_req_t dreq;
	srg_pkg::div_rsp_t drsp;
	logic [W-1:0]  ma, mp;
	logic [16:0]   mb;

	srg_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));
	srg_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

	// decoded input
	logic signed [CW-1:0] in_l, in_t, in_r, in_b;
	assign in_l = s_axis_tdata[CW-1:0];
	assign in_t = s_axis_tdata[16 +: CW];
	assign in_r = s_axis_tdata[32 +: CW];
	assign in_b = s_axis_tdata[48 +: CW];

	logic signed [CW-1:0] k_cl, k_cr, k_ct, k_cb;
	assign k_cl = cliph_q[CW-1:0];
	assign k_cr = cliph_q[16 +: CW];
	assign k_ct = clipv_q[CW-1:0];
	assign k_cb = clipv_q[16 +: CW];

	logic reject;
	always_comb begin
		reject = (in_t > k_cb) || (in_b <= k_ct) || (in_l > k_cr) || (in_r <= k_cl) ||
		         (k_cb <= k_ct) || (k_cr <= k_cl) || (in_b <= in_t) || (in_r <= in_l);
	end

	function automatic logic [16:0] dif(input logic signed [CW-1:0] a,
	                                    input logic signed [CW-1:0] b);
		logic signed [CW:0] d;
		d = {a[CW-1], a} - {b[CW-1], b};
		dif = 17'(d);
	endfunction

	// job decode
	logic [1:0] jc;
	logic [1:0] jk;
	assign jc = idx_q[1:0];
	assign jk = idx_q[3:2];

	logic        clip_hit;   // current clip job applies
	logic [16:0] clip_n;
	logic [W-1:0] div_num;
	logic [16:0] div_den;
	always_comb begin
		clip_hit = 1'b0;
		clip_n   = '0;
		div_num  = '0;
		div_den  = '0;
		ma       = '0;
		mb       = '0;
		case (st_q)
			srg_pkg::ST_VSTEP: begin
				div_num = jk[0] ? cor_q[2][jc] - cor_q[1][jc] : cor_q[3][jc] - cor_q[0][jc];
				div_den = hgt_q;
			end
			srg_pkg::ST_VCLIP: begin
				// jk: 0 tl, 1 tr (top clip), 2 bl, 3 br (bottom clip)
				clip_hit = jk[1] ? (bot_q > cb_q) : (top_q < ct_q);
				clip_n   = jk[1] ? dif(bot_q, cb_q) : dif(ct_q, top_q);
				ma       = vs_q[jk[0]][jc];
				mb       = clip_n;
			end
			srg_pkg::ST_HSTEP: begin
				div_num = jk[0] ? cor_q[2][jc] - cor_q[3][jc] : cor_q[1][jc] - cor_q[0][jc];
				div_den = wid_q;
			end
			srg_pkg::ST_HCLIP: begin
				// jk: 0 tl, 1 bl (left clip), 2 tr, 3 br (right clip)
				clip_hit = jk[1] ? (right_q > cr_q) : (left_q < cl_q);
				clip_n   = jk[1] ? dif(right_q, cr_q) : dif(cl_q, left_q);
				ma       = hs_q[jk[0]][jc];
				mb       = clip_n;
			end
			srg_pkg::ST_FINAL: begin
				case (jk)
					2'd0: begin
						div_num = cor_q[3][jc] - cor_q[0][jc];
						div_den = dif(bot_q, top_q);
					end
					2'd1: begin
						div_num = cor_q[2][jc] - cor_q[1][jc];
						div_den = dif(bot_q, top_q);
					end
					default: begin
						div_num = cor_q[1][jc] - cor_q[0][jc];
						div_den = dif(right_q, left_q);
					end
				endcase
			end
			srg_pkg::ST_ROW: begin
				div_num = re_q[jc] - le_q[jc];
				div_den = dif(ex_q, sx_q);
			end
			default: ;
		endcase
		dreq.num   = div_num;
		dreq.den   = {{(W-17){div_den[16]}}, div_den};
		dreq.start = (sub_q == 2'd0) &&
		             (st_q == srg_pkg::ST_VSTEP || st_q == srg_pkg::ST_HSTEP ||
		              st_q == srg_pkg::ST_FINAL || st_q == srg_pkg::ST_ROW);
	end

	logic [3:0] last_idx;
	assign last_idx = (st_q == srg_pkg::ST_VSTEP || st_q == srg_pkg::ST_HSTEP) ? 4'd7 :
	                  (st_q == srg_pkg::ST_FINAL) ? 4'd11 :
	                  (st_q == srg_pkg::ST_ROW)   ? 4'd3 : 4'd15;

	// job done this cycle
	logic job_done;
	always_comb begin
		case (st_q)
			srg_pkg::ST_VCLIP, srg_pkg::ST_HCLIP: job_done = !clip_hit || (sub_q == 2'd1);
			srg_pkg::ST_VSTEP, srg_pkg::ST_HSTEP,
			srg_pkg::ST_FINAL, srg_pkg::ST_ROW:   job_done = drsp.done;
			default:                              job_done = 1'b0;
		endcase
	end

	logic phase_end;
	assign phase_end = job_done && (idx_q == last_idx);

	// clipped box that phases leave behind
	logic signed [CW-1:0] top_c, bot_c, left_c, right_c;
	assign top_c   = (top_q < ct_q) ? ct_q : top_q;
	assign bot_c   = (bot_q > cb_q) ? cb_q : bot_q;
	assign left_c  = (left_q < cl_q) ? cl_q : left_q;
	assign right_c = (right_q > cr_q) ? cr_q : right_q;

	logic s_acc, m_acc, is_start;
	assign s_acc    = s_axis_tvalid && s_axis_tready;
	assign m_acc    = m_axis_tvalid && m_axis_tready;
	assign is_start = (srg_pkg::cmd_t'(s_axis_tuser) == srg_pkg::CMD_START);

	// pixel advance
	logic signed [CW-1:0] nx, ny;
	assign nx = cx_q + 1'b1;
	assign ny = cy_q + 1'b1;

	// next state
	always_comb begin
		st_d = st_q;
		s_axis_tready = (st_q == srg_pkg::ST_IDLE);
		case (st_q)
			srg_pkg::ST_IDLE:
				if (s_acc) begin
					if (is_start)
						st_d = reject ? srg_pkg::ST_IDLE : srg_pkg::ST_VSTEP;
					else if (active_q)
						st_d = srg_pkg::ST_OUT;
				end
			srg_pkg::ST_VSTEP: if (phase_end) st_d = srg_pkg::ST_VCLIP;
			srg_pkg::ST_VCLIP:
				if (phase_end) begin
					if (bot_c <= top_c)
						st_d = srg_pkg::ST_IDLE;
					else if (left_q < cl_q || right_q > cr_q)
						st_d = srg_pkg::ST_HSTEP;
					else if (right_q <= left_q)
						st_d = srg_pkg::ST_IDLE;
					else
						st_d = srg_pkg::ST_FINAL;
				end
			srg_pkg::ST_HSTEP: if (phase_end) st_d = srg_pkg::ST_HCLIP;
			srg_pkg::ST_HCLIP:
				if (phase_end)
					st_d = (right_c <= left_c) ? srg_pkg::ST_IDLE : srg_pkg::ST_FINAL;
			srg_pkg::ST_FINAL: if (phase_end) st_d = srg_pkg::ST_IDLE;
			srg_pkg::ST_OUT:
				// cursor already advanced at the step beat
				if (m_acc)
					st_d = (!last_q && cx_q >= ex_q) ? srg_pkg::ST_ROW : srg_pkg::ST_IDLE;
			srg_pkg::ST_ROW: if (phase_end) st_d = srg_pkg::ST_IDLE;
			default: st_d = srg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= srg_pkg::ST_IDLE;
			idx_q    <= '0;
			sub_q    <= '0;
			active_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_d != st_q) begin
				idx_q <= '0;
				sub_q <= '0;
			end else if (job_done) begin
				idx_q <= idx_q + 1'b1;
				sub_q <= '0;
			end else if (sub_q != 2'd1) begin
				sub_q <= sub_q + 1'b1;
			end
			if (s_acc && is_start)
				active_q <= 1'b0;
			if (st_q == srg_pkg::ST_FINAL && phase_end)
				active_q <= 1'b1;
			if (st_q == srg_pkg::ST_OUT && m_acc && last_q)
				active_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (st_q == srg_pkg::ST_IDLE && s_acc && is_start) begin
			left_q <= in_l;  top_q <= in_t;  right_q <= in_r;  bot_q <= in_b;
			cl_q <= k_cl;  cr_q <= k_cr;  ct_q <= k_ct;  cb_q <= k_cb;
			hgt_q <= dif(in_b, in_t);
			wid_q <= dif(in_r, in_l);
			for (int c = 0; c < NC; c++)
				for (int k = 0; k < 4; k++)
					cor_q[k][c] <= srg_pkg::chan(col_q[k], c);
		end
		case (st_q)
			srg_pkg::ST_VSTEP:
				if (drsp.done) vs_q[jk[0]][jc] <= drsp.quo;
			srg_pkg::ST_VCLIP: begin
				if (clip_hit && sub_q == 2'd1) begin
					case (jk)
						2'd0: cor_q[0][jc] <= cor_q[0][jc] + mp;
						2'd1: cor_q[1][jc] <= cor_q[1][jc] + mp;
						2'd2: cor_q[3][jc] <= cor_q[3][jc] - mp;
						default: cor_q[2][jc] <= cor_q[2][jc] - mp;
					endcase
				end
				if (phase_end) begin
					top_q <= top_c;
					bot_q <= bot_c;
				end
			end
			srg_pkg::ST_HSTEP:
				if (drsp.done) hs_q[jk[0]][jc] <= drsp.quo;
			srg_pkg::ST_HCLIP: begin
				if (clip_hit && sub_q == 2'd1) begin
					case (jk)
						2'd0: cor_q[0][jc] <= cor_q[0][jc] + mp;
						2'd1: cor_q[3][jc] <= cor_q[3][jc] + mp;
						2'd2: cor_q[1][jc] <= cor_q[1][jc] - mp;
						default: cor_q[2][jc] <= cor_q[2][jc] - mp;
					endcase
				end
				if (phase_end) begin
					left_q  <= left_c;
					right_q <= right_c;
				end
			end
			srg_pkg::ST_FINAL: begin
				if (drsp.done) begin
					case (jk)
						2'd0: les_q[jc] <= drsp.quo;
						2'd1: res_q[jc] <= drsp.quo;
						default: ss_q[jc] <= drsp.quo;
					endcase
				end
				if (phase_end) begin
					for (int c = 0; c < NC; c++) begin
						le_q[c] <= cor_q[0][c];
						re_q[c] <= cor_q[1][c];
						sa_q[c] <= cor_q[0][c];
					end
					cx_q <= left_q;  cy_q <= top_q;
					sx_q <= left_q;  ex_q <= right_q;  ey_q <= bot_q;
				end
			end
			srg_pkg::ST_ROW:
				if (drsp.done) ss_q[jc] <= drsp.quo;
			default: ;
		endcase

		// step: latch output, advance
		if (st_q == srg_pkg::ST_IDLE && s_acc && !is_start && active_q) begin
			obuf_q <= {(alpha_q ? sa_q[3][30:23] : 8'd0), sa_q[2][30:23], sa_q[1][30:23],
			           sa_q[0][30:23], 16'(cy_q), 16'(cx_q)};
			for (int c = 0; c < NC; c++) sa_q[c] <= sa_q[c] + ss_q[c];
			last_q <= (nx >= ex_q) && (ny >= ey_q);
			cx_q   <= nx;
			if (nx >= ex_q) begin
				for (int c = 0; c < NC; c++) begin
					le_q[c] <= le_q[c] + les_q[c];
					re_q[c] <= re_q[c] + res_q[c];
				end
				cy_q <= ny;
			end
		end
		if (st_q == srg_pkg::ST_OUT && m_acc && !last_q && cx_q >= ex_q) begin
			cx_q <= sx_q;
			for (int c = 0; c < NC; c++) sa_q[c] <= le_q[c];
		end
	end

	assign m_axis_tvalid = (st_q == srg_pkg::ST_OUT);
	assign m_axis_tdata  = obuf_q;
	assign m_axis_tlast  = last_q;

endmodule

// ===== sv/srg_div.sv =====
// ----------------------------------------------------------------------------
// srg_div: shared signed divider
// Restoring radix-2 division, one quotient bit per cycle, signed numerator
// over a positive denominator, truncating toward zero. A denominator that is
// not positive gives zero.
// ----------------------------------------------------------------------------
module srg_div (
	input  logic                clk,
	input  logic                arst_n,
	input  srg_pkg::div_req_t   req,
	output srg_pkg::div_rsp_t   rsp
);
	localparam int W = srg_pkg::ACC_W;

	logic [W-1:0]            rem_q;
	logic [W-1:0]            quo_q;
	logic [W-1:0]            den_q;
	logic                    neg_q;
	logic                    zero_q;
	logic [$clog2(W+1)-1:0]  cnt_q;
	logic                    busy_q;
	logic                    done_q;

	logic [W:0]   trial;
	logic [W-1:0] shifted;

	// one restoring step
	always_comb begin
		shifted = {rem_q[W-2:0], quo_q[W-1]};
		trial   = {1'b0, shifted} - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ($clog2(W+1))'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ($clog2(W+1))'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			quo_q  <= req.num[W-1] ? (~req.num + 1'b1) : req.num;
			den_q  <= req.den;
			neg_q  <= req.num[W-1];
			zero_q <= req.den[W-1] || (req.den == '0);
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		if (zero_q)
			rsp.quo = '0;
		else
			rsp.quo = neg_q ? (~quo_q + 1'b1) : quo_q;
	end

endmodule

// ===== sv/srg_mul.sv =====
// ----------------------------------------------------------------------------
// srg_mul: shared clip multiplier
// Registered 32 x 17 bit product, low 32 bits kept (wrapping).
// ----------------------------------------------------------------------------
module srg_mul (
	input  logic                       clk,
	input  logic [srg_pkg::ACC_W-1:0]  a,
	input  logic [16:0]                b,
	output logic [srg_pkg::ACC_W-1:0]  p
);
	logic [srg_pkg::ACC_W+16:0] full;

	always_comb full = a * b;

	always_ff @(posedge clk) begin
		p <= full[srg_pkg::ACC_W-1:0];
	end

endmodule
